// ===== sv/lfrr_pkg.sv =====
package lfrr_pkg;

	localparam int CHANNELS = 6;
	localparam int DUTY_W   = 11;
	localparam int SRC_W    = 3;
	localparam int ROW_W    = 4;
	localparam int ROWS     = 11;

	localparam logic [DUTY_W-1:0] FULL_SCALE = 11'd1800;
	localparam logic [DUTY_W-1:0] HALF_HI    = 11'd1600;
	localparam logic [DUTY_W-1:0] HALF_LO    = 11'd1200;
	localparam logic [DUTY_W-1:0] FAST_LO    = 11'd1000;

	// configuration register indexes
	localparam logic [1:0] CFG_KEY_COUNT  = 2'd0;
	localparam logic [1:0] CFG_BOARD      = 2'd1;
	localparam logic [1:0] CFG_TWO_LAYOUT = 2'd2;

	// board variants; code 3 behaves as standard
	localparam logic [1:0] BOARD_STD     = 2'd0;
	localparam logic [1:0] BOARD_NO_BACK = 2'd1;
	localparam logic [1:0] BOARD_ALT     = 2'd2;

	// two-key layouts
	localparam logic [1:0] LAYOUT_VERT  = 2'd0;
	localparam logic [1:0] LAYOUT_HORIZ = 2'd1;
	localparam logic [1:0] LAYOUT_OUTER = 2'd2;

	// routing rows
	localparam logic [ROW_W-1:0] ROW_SIX        = 4'd0;
	localparam logic [ROW_W-1:0] ROW_FIVE       = 4'd1;
	localparam logic [ROW_W-1:0] ROW_FOUR       = 4'd2;
	localparam logic [ROW_W-1:0] ROW_THREE_ALT  = 4'd3;
	localparam logic [ROW_W-1:0] ROW_THREE_STD  = 4'd4;
	localparam logic [ROW_W-1:0] ROW_TWO_ALT    = 4'd5;
	localparam logic [ROW_W-1:0] ROW_TWO_VERT   = 4'd6;
	localparam logic [ROW_W-1:0] ROW_TWO_HORIZ  = 4'd7;
	localparam logic [ROW_W-1:0] ROW_TWO_OUTER  = 4'd8;
	localparam logic [ROW_W-1:0] ROW_ONE_ALT    = 4'd9;
	localparam logic [ROW_W-1:0] ROW_ONE_STD    = 4'd10;

	localparam logic [SRC_W-1:0] NO_SRC = 3'd7;

	// per row: six indicator sources, then six backlight sources
	localparam logic [SRC_W-1:0] ROUTE [ROWS][2*CHANNELS] = '{
		'{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
		'{3'd0, 3'd3, 3'd4, 3'd1, 3'd2, 3'd4, 3'd0, 3'd3, 3'd4, 3'd1, 3'd2, 3'd4},
		'{3'd0, 3'd1, 3'd2, 3'd3, NO_SRC, NO_SRC, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd3},
		'{3'd0, 3'd1, 3'd2, 3'd2, 3'd0, 3'd2, 3'd0, 3'd1, 3'd2, 3'd2, 3'd0, 3'd2},
		'{3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2},
		'{3'd0, 3'd0, 3'd1, 3'd1, NO_SRC, NO_SRC, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd1},
		'{3'd0, 3'd0, 3'd1, 3'd1, NO_SRC, NO_SRC, 3'd0, 3'd0, 3'd1, 3'd1, NO_SRC, NO_SRC},
		'{3'd1, 3'd0, 3'd0, 3'd1, NO_SRC, NO_SRC, 3'd1, 3'd0, 3'd0, 3'd1, NO_SRC, NO_SRC},
		'{NO_SRC, 3'd1, NO_SRC, NO_SRC, 3'd0, NO_SRC,
			NO_SRC, 3'd1, NO_SRC, NO_SRC, 3'd0, NO_SRC},
		'{3'd0, 3'd0, NO_SRC, NO_SRC, NO_SRC, NO_SRC,
			3'd0, 3'd0, NO_SRC, NO_SRC, 3'd0, NO_SRC},
		'{NO_SRC, 3'd0, NO_SRC, NO_SRC, 3'd0, NO_SRC,
			NO_SRC, 3'd0, NO_SRC, NO_SRC, 3'd0, NO_SRC}
	};

	typedef logic [DUTY_W-1:0] duty_t;

endpackage

// ===== sv/led_fade_ramp_router_unit.sv =====
// Six-channel LED fade engine with routed PWM outputs. Each accepted beat on the
// tick channel is one fade step: start_mask marks channels active, led_on_mask picks
// ramp down (toward 0) or up (toward 1800, then stop). Ramp down runs at half rate
// while the duty lies in 1200..1599. When any active channel below key_count remains,
// the twelve PWM registers are reloaded through a routing chosen by key_count,
// board_variant and two_key_layout; every tick returns one beat with all twelve.
// A tick goes through the input register, then the update that loads the result
// registers; a new tick is taken every cycle while results drain. One stalled tick
// waits in the input register while a result is held. The user must write the
// configuration (cfg_we/cfg_index/cfg_data) while the block is idle; not enforced.
module led_fade_ramp_router_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data,

	input  logic        tick_valid,
	output logic        tick_ready,
	input  logic [5:0]  start_mask,
	input  logic [5:0]  led_on_mask,

	output logic        duty_valid,
	input  logic        duty_ready,
	output logic [10:0] led_duty_0,
	output logic [10:0] led_duty_1,
	output logic [10:0] led_duty_2,
	output logic [10:0] led_duty_3,
	output logic [10:0] led_duty_4,
	output logic [10:0] led_duty_5,
	output logic [10:0] back_duty_0,
	output logic [10:0] back_duty_1,
	output logic [10:0] back_duty_2,
	output logic [10:0] back_duty_3,
	output logic [10:0] back_duty_4,
	output logic [10:0] back_duty_5
);

	localparam int N = lfrr_pkg::CHANNELS;

	logic [2:0] key_count_q;
	logic [1:0] board_q;
	logic [1:0] layout_q;

	logic         valid_s1;
	logic [N-1:0] start_s1;
	logic [N-1:0] on_s1;

	lfrr_pkg::duty_t duty_q   [N];
	logic [N-1:0]    phase_q;
	logic [N-1:0]    active_q;
	lfrr_pkg::duty_t led_out_q  [N];
	lfrr_pkg::duty_t back_out_q [N];
	logic            out_valid_q;

	lfrr_pkg::duty_t duty_d   [N];
	logic [N-1:0]    phase_d;
	logic [N-1:0]    active_d;
	lfrr_pkg::duty_t led_out_d  [N];
	lfrr_pkg::duty_t back_out_d [N];

	logic                       advance;
	logic                       any_key;
	logic                       row_ok;
	logic [lfrr_pkg::ROW_W-1:0] row;

	assign advance    = !out_valid_q || duty_ready;
	assign tick_ready = !valid_s1 || advance;
	assign duty_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= 3'd6;
			board_q     <= lfrr_pkg::BOARD_STD;
			layout_q    <= lfrr_pkg::LAYOUT_VERT;
		end else if (cfg_we) begin
			case (cfg_index)
				lfrr_pkg::CFG_KEY_COUNT:  key_count_q <= cfg_data;
				lfrr_pkg::CFG_BOARD:      board_q     <= cfg_data[1:0];
				lfrr_pkg::CFG_TWO_LAYOUT: layout_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_ready && tick_valid) begin
			start_s1 <= start_mask;
			on_s1    <= led_on_mask;
		end
	end

	// ramp every channel
	always_comb begin
		for (int i = 0; i < N; i++) begin
			duty_d[i]   = duty_q[i];
			phase_d[i]  = phase_q[i];
			active_d[i] = active_q[i] | start_s1[i];
			if (active_d[i]) begin
				if (on_s1[i]) begin
					if (duty_q[i] >= lfrr_pkg::HALF_LO && duty_q[i] < lfrr_pkg::HALF_HI) begin
						phase_d[i] = !phase_q[i];
						if (phase_q[i]) begin
							duty_d[i] = duty_q[i] - 11'd1;
						end
					end else if (duty_q[i] >= lfrr_pkg::FAST_LO && duty_q[i] < lfrr_pkg::HALF_LO) begin
						phase_d[i] = 1'b0;
						duty_d[i]  = duty_q[i] - 11'd1;
					end else if (duty_q[i] != '0) begin
						duty_d[i] = duty_q[i] - 11'd1;
					end else begin
						active_d[i] = 1'b0;
					end
				end else begin
					phase_d[i] = 1'b0;
					if (duty_q[i] + 11'd1 >= lfrr_pkg::FULL_SCALE) begin
						duty_d[i]   = lfrr_pkg::FULL_SCALE;
						active_d[i] = 1'b0;
					end else begin
						duty_d[i] = duty_q[i] + 11'd1;
					end
				end
			end
		end
	end

	always_comb begin
		any_key = 1'b0;
		for (int i = 0; i < N; i++) begin
			if (3'(i) < key_count_q && active_d[i]) begin
				any_key = 1'b1;
			end
		end
	end

	// routing row select
	always_comb begin
		row    = lfrr_pkg::ROW_SIX;
		row_ok = 1'b1;
		case (key_count_q)
			3'd6: row = lfrr_pkg::ROW_SIX;
			3'd5: row = lfrr_pkg::ROW_FIVE;
			3'd4: row = lfrr_pkg::ROW_FOUR;
			3'd3: row = (board_q == lfrr_pkg::BOARD_ALT) ?
				lfrr_pkg::ROW_THREE_ALT : lfrr_pkg::ROW_THREE_STD;
			3'd2: begin
				if (board_q == lfrr_pkg::BOARD_ALT) begin
					row = lfrr_pkg::ROW_TWO_ALT;
				end else begin
					case (layout_q)
						lfrr_pkg::LAYOUT_VERT:  row = lfrr_pkg::ROW_TWO_VERT;
						lfrr_pkg::LAYOUT_HORIZ: row = lfrr_pkg::ROW_TWO_HORIZ;
						lfrr_pkg::LAYOUT_OUTER: row = lfrr_pkg::ROW_TWO_OUTER;
						default:                row_ok = 1'b0;
					endcase
				end
			end
			3'd1: row = (board_q == lfrr_pkg::BOARD_ALT) ?
				lfrr_pkg::ROW_ONE_ALT : lfrr_pkg::ROW_ONE_STD;
			default: row_ok = 1'b0;
		endcase
	end

	always_comb begin
		logic [lfrr_pkg::SRC_W-1:0] ls;
		logic [lfrr_pkg::SRC_W-1:0] bs;
		for (int i = 0; i < N; i++) begin
			ls            = lfrr_pkg::ROUTE[row][i];
			bs            = lfrr_pkg::ROUTE[row][i+N];
			led_out_d[i]  = led_out_q[i];
			back_out_d[i] = back_out_q[i];
			if (any_key && row_ok) begin
				if (ls < 3'(N)) begin
					led_out_d[i] = duty_d[ls];
				end
				if (bs < 3'(N) && board_q != lfrr_pkg::BOARD_NO_BACK) begin
					back_out_d[i] = lfrr_pkg::FULL_SCALE - duty_d[bs];
				end
			end
		end
	end

	// fade state and result registers move together, only when the result slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				duty_q[i]     <= lfrr_pkg::FULL_SCALE;
				led_out_q[i]  <= '0;
				back_out_q[i] <= '0;
			end
			phase_q     <= '0;
			active_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				for (int i = 0; i < N; i++) begin
					duty_q[i]     <= duty_d[i];
					led_out_q[i]  <= led_out_d[i];
					back_out_q[i] <= back_out_d[i];
				end
				phase_q  <= phase_d;
				active_q <= active_d;
			end
		end
	end

	assign led_duty_0  = led_out_q[0];
	assign led_duty_1  = led_out_q[1];
	assign led_duty_2  = led_out_q[2];
	assign led_duty_3  = led_out_q[3];
	assign led_duty_4  = led_out_q[4];
	assign led_duty_5  = led_out_q[5];
	assign back_duty_0 = back_out_q[0];
	assign back_duty_1 = back_out_q[1];
	assign back_duty_2 = back_out_q[2];
	assign back_duty_3 = back_out_q[3];
	assign back_duty_4 = back_out_q[4];
	assign back_duty_5 = back_out_q[5];

`ifndef SYNTH
	for (genvar g = 0; g < N; g++) begin : g_chk
		a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
			duty_q[g] <= lfrr_pkg::FULL_SCALE)
			else $error("fade duty above full scale");
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !duty_ready |=> out_valid_q && $stable(led_out_q[0])
			&& $stable(back_out_q[0]) && $stable(duty_q[0]))
		else $error("result or fade state moved during stall");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(start_s1) && $stable(on_s1))
		else $error("held tick lost");
`endif

endmodule
